// ===== hw/rtl/mpid_pkg.sv =====
// Package for the multichannel PID controller.
// Holds the request types, register and state codes, and sizing constants.
// No dependencies.
package mpid_pkg;

    localparam int CHANNELS = 9;
    localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_W     = 4;
    localparam int ERR_W    = 20;
    localparam int GAIN_W   = 16;
    localparam int INTEG_W  = 48;
    localparam int DRIVE_W  = 32;
    localparam int STATE_W  = INTEG_W + ERR_W;
    localparam int CFG_IW   = 3;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd205;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd1280;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd102;
    localparam logic [GAIN_W-1:0] STEP_TIME_RST  = 16'd3277;
    localparam logic [GAIN_W-1:0] STEP_RATE_RST  = 16'd320;

    typedef struct packed {
        logic [CH_W-1:0]         channel;
        logic signed [ERR_W-1:0] error_sample;
    } t_in_req;

    typedef struct packed {
        logic [CH_W-1:0]           out_channel;
        logic signed [DRIVE_W-1:0] drive;
    } t_out_req;

    typedef enum logic [CFG_IW-1:0] {
        CFG_PROP_GAIN  = 3'd0,
        CFG_INTEG_GAIN = 3'd1,
        CFG_DERIV_GAIN = 3'd2,
        CFG_STEP_TIME  = 3'd3,
        CFG_STEP_RATE  = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_SUM
    } t_state;

endpackage

// ===== hw/rtl/mpid_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; no package dependencies.
module mpid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/multichannel_pid_controller_top.sv =====
// Top level of the multichannel PID controller.
// Depends on mpid_pkg and on mpid_ram, which holds the per-channel state.
//
// Usage: an input request carries a channel number and a signed Q12.8 error.
// One output request follows per input, carrying the channel and the
// saturated Q24.8 drive value. Channels at or above CHANNELS give drive zero
// and leave all state alone. Both data channels use valid/ready; gains and
// step values are written over the configuration channel, which is always
// ready. The user is bound to write them only while the block is idle; the
// block itself does no such check. An accepted request passes the read,
// multiply (with write-back) and sum steps on the single state memory, and a
// new request is accepted only after its result is loaded in the output register.
// The input is accepted again while a finished result waits in the output
// register; if that register is still full when the next sum is ready, the
// sequencer holds until the receiver takes the waiting result.
// Reset restores the default gains and marks every channel's integral and
// previous error as zero through a valid bit per channel; no clearing pass.
module multichannel_pid_controller_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  mpid_pkg::t_in_req             i_in_req,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output mpid_pkg::t_out_req            o_out_req,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mpid_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [mpid_pkg::GAIN_W-1:0]   i_cfg_data
);
    import mpid_pkg::*;

    localparam int CH_CW = CH_AW + CH_W;

    t_state r_state, n_state;

    logic [GAIN_W-1:0] r_prop_gain, r_integ_gain, r_deriv_gain, r_step_time, r_step_rate;

    t_in_req            r_in;
    logic               r_oor;
    logic [CH_AW-1:0]   r_addr;
    logic [CHANNELS-1:0] r_vld;
    logic               r_rd_vld;

    logic signed [INTEG_W-1:0] r_integ;
    logic signed [36:0]        r_p;
    logic signed [37:0]        r_dr;
    logic [39:0]               r_ilo;
    logic signed [40:0]        r_ihi;
    logic signed [54:0]        r_dd;

    logic     r_out_valid;
    t_out_req r_out;

    logic               in_acc;
    logic               ram_re, ram_we, out_load;
    logic [CH_CW-1:0]   ch_ext;
    logic               ch_oor;
    logic [CH_AW-1:0]   ch_addr;
    logic [STATE_W-1:0] ram_rdata;
    logic [STATE_W-1:0] ram_wdata;

    logic signed [INTEG_W-1:0] integ_old;
    logic signed [ERR_W-1:0]   last_old;
    logic signed [36:0]        it_prod;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integ_new;
    logic signed [ERR_W:0]     diff;
    logic signed [28:0]        p_term;
    logic signed [41:0]        i_term;
    logic signed [34:0]        d_term;
    logic signed [42:0]        total;
    logic signed [DRIVE_W-1:0] drive;

    assign ch_ext  = {{CH_AW{1'b0}}, i_in_req.channel};
    assign ch_oor  = (ch_ext >= CH_CW'(CHANNELS));
    assign ch_addr = ch_ext[CH_AW-1:0];
    assign in_acc  = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_MUL;
            ST_MUL:  n_state = ST_SUM;
            ST_SUM: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        ram_we     = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_READ: ;
            ST_MUL:  ram_we = !r_oor;
            ST_SUM:  out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    assign ram_re    = in_acc && !ch_oor;
    assign ram_wdata = {r_integ, r_in.error_sample};

    mpid_ram #(
        .WIDTH(STATE_W),
        .DEPTH(CHANNELS)
    ) u_state_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_addr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ch_addr),
        .o_rdata(ram_rdata)
    );

    // Read step: merge the stored state, update the integral, form products.
    always_comb begin
        integ_old = r_rd_vld ? $signed(ram_rdata[STATE_W-1:ERR_W]) : '0;
        last_old  = r_rd_vld ? $signed(ram_rdata[ERR_W-1:0]) : '0;
        it_prod   = r_in.error_sample * $signed({1'b0, r_step_time});
        integ_sum = {integ_old[INTEG_W-1], integ_old}
                  + {{(INTEG_W-36){it_prod[36]}}, it_prod};
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            integ_new = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                           : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            integ_new = integ_sum[INTEG_W-1:0];
        end
        diff = {r_in.error_sample[ERR_W-1], r_in.error_sample}
             - {last_old[ERR_W-1], last_old};
    end

    // Sum step: the integral term is rebuilt from its two partial products.
    always_comb begin
        p_term = 29'(r_p >>> 8);
        i_term = {r_ihi[40], r_ihi} + 42'($signed({1'b0, r_ilo[39:24]}));
        d_term = 35'(r_dd >>> 20);
        total  = 43'(p_term) + 43'(i_term) + 43'(d_term);
        if (total[42:31] != {12{total[31]}}) begin
            drive = total[42] ? {1'b1, {(DRIVE_W-1){1'b0}}} : {1'b0, {(DRIVE_W-1){1'b1}}};
        end else begin
            drive = total[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_vld        <= '0;
            r_out_valid  <= 1'b0;
            r_prop_gain  <= PROP_GAIN_RST;
            r_integ_gain <= INTEG_GAIN_RST;
            r_deriv_gain <= DERIV_GAIN_RST;
            r_step_time  <= STEP_TIME_RST;
            r_step_rate  <= STEP_RATE_RST;
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_vld[r_addr] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_PROP_GAIN:  r_prop_gain  <= i_cfg_data;
                    CFG_INTEG_GAIN: r_integ_gain <= i_cfg_data;
                    CFG_DERIV_GAIN: r_deriv_gain <= i_cfg_data;
                    CFG_STEP_TIME:  r_step_time  <= i_cfg_data;
                    CFG_STEP_RATE:  r_step_rate  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in     <= i_in_req;
            r_oor    <= ch_oor;
            r_addr   <= ch_addr;
            r_rd_vld <= !ch_oor && r_vld[ch_addr];
        end
        if (r_state == ST_READ) begin
            r_integ <= integ_new;
            r_p     <= r_in.error_sample * $signed({1'b0, r_prop_gain});
            r_dr    <= diff * $signed({1'b0, r_step_rate});
        end
        if (r_state == ST_MUL) begin
            r_ilo <= r_integ[23:0] * r_integ_gain;
            r_ihi <= $signed(r_integ[INTEG_W-1:24]) * $signed({1'b0, r_integ_gain});
            r_dd  <= r_dr * $signed({1'b0, r_deriv_gain});
        end
        if (out_load) begin
            r_out.out_channel <= r_in.channel;
            r_out.drive       <= r_oor ? '0 : drive;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

// ===== tb/multichannel_pid_controller_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench for multichannel_pid_controller_top: drives error requests and gain writes,
// predicts every drive value in a scoreboard class and checks each output request.
// Depends on mpid_pkg and the multichannel_pid_controller_top RTL.
module multichannel_pid_controller_top_tb;
    import mpid_pkg::*;

    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     RX_HOLD_CYCLES = 300;
    localparam int     SETTLE_CYCLES  = 8;
    localparam int     MAX_GAP        = 64;
    localparam int     WINDUP_ITEMS   = 8;
    localparam longint INTEG_HI       = (longint'(1) <<< (INTEG_W - 1)) - 1;
    localparam longint INTEG_LO       = -(longint'(1) <<< (INTEG_W - 1));
    localparam longint DRIVE_HI       = (longint'(1) <<< (DRIVE_W - 1)) - 1;
    localparam longint DRIVE_LO       = -(longint'(1) <<< (DRIVE_W - 1));
    localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W - 1){1'b1}}};
    localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W - 1){1'b0}}};
    localparam logic [GAIN_W-1:0]       GAIN_MAX = '1;

    class pid_drive_tracker;
        t_out_req                  drive_q[$];
        logic signed [INTEG_W-1:0] integ_acc[CHANNELS];
        logic signed [ERR_W-1:0]   prev_err[CHANNELS];
        logic [GAIN_W-1:0]         kp, ki, kd, dt, rate;
        int                        errors;

        function new();
            kp   = PROP_GAIN_RST;
            ki   = INTEG_GAIN_RST;
            kd   = DERIV_GAIN_RST;
            dt   = STEP_TIME_RST;
            rate = STEP_RATE_RST;
            errors = 0;
            for (int c = 0; c < CHANNELS; c++) begin
                integ_acc[c] = '0;
                prev_err[c]  = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IW-1:0] idx, logic [GAIN_W-1:0] val);
            case (t_cfg_idx'(idx))
                CFG_PROP_GAIN:  kp   = val;
                CFG_INTEG_GAIN: ki   = val;
                CFG_DERIV_GAIN: kd   = val;
                CFG_STEP_TIME:  dt   = val;
                CFG_STEP_RATE:  rate = val;
                default: ;
            endcase
        endfunction

        function void note_request(t_in_req req);
            longint   e, acc, p, i, d, sum;
            int       c;
            t_out_req want;
            e = longint'(req.error_sample);
            want.out_channel = req.channel;
            want.drive = '0;
            if (req.channel < CHANNELS) begin
                c = int'(req.channel);
                acc = longint'(integ_acc[c]) + e * longint'(dt);
                if (acc > INTEG_HI) acc = INTEG_HI;
                if (acc < INTEG_LO) acc = INTEG_LO;
                integ_acc[c] = acc[INTEG_W-1:0];
                p = (e * longint'(kp)) >>> 8;
                i = (acc * longint'(ki)) >>> 24;
                d = ((e - longint'(prev_err[c])) * longint'(rate) * longint'(kd)) >>> 20;
                sum = p + i + d;
                if (sum > DRIVE_HI) sum = DRIVE_HI;
                if (sum < DRIVE_LO) sum = DRIVE_LO;
                want.drive = sum[DRIVE_W-1:0];
                prev_err[c] = req.error_sample;
            end
            drive_q.push_back(want);
        endfunction

        task report(string what);
            errors++;
            $display("%0t mismatch: %s", $realtime, what);
        endtask

        task check_result(t_out_req got);
            t_out_req want;
            if (drive_q.size() == 0) begin
                report($sformatf("unexpected result ch %0d drive %0d",
                                 got.out_channel, got.drive));
            end else begin
                want = drive_q.pop_front();
                if (got.out_channel !== want.out_channel)
                    report($sformatf("channel got %0d want %0d",
                                     got.out_channel, want.out_channel));
                if (got.drive !== want.drive)
                    report($sformatf("ch %0d drive got %0d want %0d",
                                     want.out_channel, got.drive, want.drive));
            end
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    t_in_req             i_in_req    = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_req            o_out_req;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_IW-1:0]   i_cfg_index = '0;
    logic [GAIN_W-1:0]   i_cfg_data  = '0;

    pid_drive_tracker sb;
    int               tx_idle_pct = 0;
    int               rx_stall_pct = 0;
    bit               rx_hold_req = 1'b0;
    bit               rx_hold_done = 1'b0;

    multichannel_pid_controller_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (o_out_valid && i_out_ready)
                sb.check_result(o_out_req);
            if (i_in_valid && o_in_ready)
                sb.note_request(i_in_req);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready) || !i_rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold_req && !rx_hold_done) begin
                i_out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                rx_hold_done = 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so the caller either sends again or drains.
    task send_request(input logic [CH_W-1:0] ch, input logic signed [ERR_W-1:0] err);
        int      gap;
        t_in_req req;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
            gap++;
        req.channel      = ch;
        req.error_sample = err;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task wait_drained();
        i_in_valid <= 1'b0;
        while (sb.drive_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task write_reg(input logic [CFG_IW-1:0] idx, input logic [GAIN_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task write_gains(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                     input logic [GAIN_W-1:0] d, input logic [GAIN_W-1:0] t,
                     input logic [GAIN_W-1:0] r);
        write_reg(CFG_PROP_GAIN, p);
        write_reg(CFG_INTEG_GAIN, i);
        write_reg(CFG_DERIV_GAIN, d);
        write_reg(CFG_STEP_TIME, t);
        write_reg(CFG_STEP_RATE, r);
    endtask

    function automatic logic [GAIN_W-1:0] pick_setting(bit is_step);
        case ($urandom_range(3))
            0:       return is_step ? GAIN_W'(1) : '0;
            1:       return GAIN_MAX;
            2:       return GAIN_W'($urandom_range(1, 1024));
            default: return GAIN_W'($urandom_range(is_step ? 1 : 0, 65535));
        endcase
    endfunction

    task send_random();
        logic [CH_W-1:0]         ch;
        logic signed [ERR_W-1:0] err;
        if ($urandom_range(19) < 18)
            ch = CH_W'($urandom_range(CHANNELS - 1));
        else
            ch = CH_W'($urandom_range(CHANNELS, 15));
        case ($urandom_range(9))
            0:       err = ERR_MAX;
            1:       err = ERR_MIN;
            2, 3, 4: err = ERR_W'($urandom_range(1023)) - ERR_W'(512);
            default: err = ERR_W'($urandom());
        endcase
        send_request(ch, err);
    endtask

    initial begin
        int phase_idle[4];
        int phase_stall[4];
        sb = new();
        phase_idle  = '{0, 77, 0, 8};
        phase_stall = '{0, 0, 77, 8};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Default gains: extremes of the error, every channel class, out-of-range channels.
        send_request(0, '0);
        send_request(0, ERR_MAX);
        send_request(0, ERR_MIN);
        send_request(8, ERR_MAX);
        send_request(8, ERR_MIN);
        send_request(9, ERR_MAX);
        send_request(15, ERR_MIN);
        send_request(7, -1);
        send_request(1, 1);
        send_request(8, 256);
        wait_drained();

        // Full-scale gains drive the output into saturation; unused indexes are ignored.
        write_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
        for (int k = int'(CFG_STEP_RATE) + 1; k < (1 << CFG_IW); k++)
            write_reg(k[CFG_IW-1:0], GAIN_W'($urandom()));
        send_request(2, ERR_MAX);
        send_request(2, ERR_MIN);
        send_request(2, ERR_MAX);
        send_request(8, ERR_MIN);
        send_request(12, ERR_MAX);
        wait_drained();

        // Zero step time holds the integral; zero step rate kills the derivative.
        write_gains(GAIN_W'(256), GAIN_MAX, GAIN_MAX, '0, '0);
        send_request(2, ERR_MIN);
        send_request(4, ERR_MAX);
        send_request(4, ERR_MIN);
        wait_drained();
        write_gains('0, '0, '0, GAIN_W'(1), GAIN_W'(1));
        send_request(4, ERR_MAX);
        send_request(8, ERR_MIN);
        wait_drained();

        // Push the integral hard in both directions.
        write_gains(GAIN_W'(1), GAIN_W'(1), GAIN_W'(1), GAIN_MAX, GAIN_MAX);
        for (int n = 0; n < WINDUP_ITEMS; n++)
            send_request(3, ERR_MAX);
        for (int n = 0; n < WINDUP_ITEMS; n++)
            send_request(5, ERR_MIN);
        send_request(3, ERR_MIN);
        send_request(5, ERR_MAX);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct  = phase_idle[ph];
            rx_stall_pct = phase_stall[ph];
            write_gains(pick_setting(0), pick_setting(0), pick_setting(0),
                        pick_setting(1), pick_setting(1));
            if (ph == 0) begin
                rx_hold_done = 1'b0;
                rx_hold_req  = 1'b1;
                repeat (24) send_random();
                wait (rx_hold_done);
                rx_hold_req = 1'b0;
                wait_drained();
            end
            repeat (80) send_random();
            wait_drained();
            write_gains(pick_setting(0), pick_setting(0), pick_setting(0),
                        pick_setting(1), pick_setting(1));
            repeat (80) send_random();
            wait_drained();
        end

        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
